### hw/rtl/rlbd_pkg.sv
// Package for the resistor-ladder button decoder: sizes, codes and the
// token that travels down the calibration cell chain.
// No dependencies.
package rlbd_pkg;

  localparam int CAL_ENTRIES   = 17;
  localparam int MATCH_ENTRIES = 16;
  localparam int SAMPLE_BITS   = 10;

  localparam int IDX_W     = 5;   // entry_index field width
  localparam int WIN_W     = 11;  // stored window bound width
  localparam int HALF_W    = 10;  // window_half_width register width
  localparam int CNT_W     = 8;   // debounce counters
  localparam int CODE_W    = 5;   // result_code width
  localparam int CFG_W     = 10;  // widest configuration register
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic signed [CODE_W-1:0] CODE_NONE = -5'sd2;  // no button or pending
  localparam logic signed [CODE_W-1:0] CODE_ZERO = -5'sd1;  // current button is 0

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH    = 2'd0,
    CFG_MISS_LIMIT    = 2'd1,
    CFG_REPEAT_TARGET = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // One item in flight along the chain
  typedef struct packed {
    logic                   valid;
    op_e                    op;
    logic [IDX_W-1:0]       idx;       // target entry for a load
    logic [SAMPLE_BITS-1:0] sample;    // sample value for a classify
    logic [WIN_W-1:0]       lo;        // unsplit low bound for a load
    logic [WIN_W-1:0]       hi;        // unsplit high bound for a load
    logic [WIN_W-1:0]       split_hi;  // split high bound from the left neighbor
    logic                   found;     // a window already matched
    logic [IDX_W-1:0]       hit_idx;   // lowest matching entry
  } token_t;

endpackage

### hw/rtl/resistor_ladder_button_decoder.sv
// Top level of the resistor-ladder button decoder: cell chain and debouncer.
// Depends on rlbd_pkg, rlbd_cell and rlbd_debounce.

// Each item enters a chain of 17 calibration cells, one cell per cycle, and
// busy stays high from the accepting edge until the item leaves the last
// cell; no new item is taken before then. A sample item gives one result,
// on result_code_o with result_valid_o high for one cycle, registered in the
// debouncer after the item leaves the last cell; the receiver must take it
// then. Load items give no result. Load calibration entries in index order
// before sending samples, and write configuration only while busy is low.
module resistor_ladder_button_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [rlbd_pkg::IDX_W-1:0]         entry_index_i,
  input  logic [rlbd_pkg::SAMPLE_BITS-1:0]   level_i,
  input  logic                               cfg_we_i,
  input  logic [rlbd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rlbd_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic                               result_valid_o,
  output logic signed [rlbd_pkg::CODE_W-1:0] result_code_o
);
  import rlbd_pkg::*;

  logic              busy_q, busy_d;
  logic              accept;
  logic [HALF_W-1:0] half_q;
  logic [CNT_W-1:0]  miss_limit_q, repeat_target_q;
  logic [WIN_W-1:0]  lvl_ext, half_ext;
  token_t            chain [CAL_ENTRIES+1];
  logic [CAL_ENTRIES-1:0] chain_valid;

  assign accept = start && !busy_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q          <= HALF_W'(5);
      miss_limit_q    <= CNT_W'(3);
      repeat_target_q <= CNT_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_WIDTH:    half_q          <= cfg_wdata_i[HALF_W-1:0];
        CFG_MISS_LIMIT:    miss_limit_q    <= cfg_wdata_i[CNT_W-1:0];
        CFG_REPEAT_TARGET: repeat_target_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Token built at entry: unsplit window bounds for a load
  assign lvl_ext  = WIN_W'(level_i);
  assign half_ext = WIN_W'(half_q);

  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = accept;
    chain[0].op       = op_e'(operation_i);
    chain[0].idx      = entry_index_i;
    chain[0].sample   = level_i;
    chain[0].lo       = (lvl_ext > half_ext) ? lvl_ext - half_ext : '0;
    chain[0].hi       = lvl_ext + half_ext;
  end

  // Cell chain, one entry per cell
  for (genvar g = 0; g < CAL_ENTRIES; g++) begin : g_cell
    rlbd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
    assign chain_valid[g] = chain[g+1].valid;
  end

  rlbd_debounce u_debounce (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_i           (chain[CAL_ENTRIES]),
    .miss_limit_i    (miss_limit_q),
    .repeat_target_i (repeat_target_q),
    .result_valid_o  (result_valid_o),
    .result_code_o   (result_code_o)
  );

  // Busy from acceptance until the item leaves the last cell
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (chain[CAL_ENTRIES].valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy = busy_q;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one item in the cell chain");

  a_busy_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid != '0) |-> busy_q)
    else $error("item in the chain while not busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && chain[1].valid))
    else $error("accepted item did not enter the chain");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(chain[CAL_ENTRIES].valid &&
                             (chain[CAL_ENTRIES].op == OP_SAMPLE)))
    else $error("result without a sample leaving the chain");
`endif

endmodule

### hw/rtl/rlbd_cell.sv
// One calibration cell: holds one window and passes the item token on.
// Depends on rlbd_pkg.
module rlbd_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [rlbd_pkg::IDX_W-1:0] cell_idx_i,
  input  rlbd_pkg::token_t  tok_i,
  output rlbd_pkg::token_t  tok_o
);
  import rlbd_pkg::*;

  logic [WIN_W-1:0] lo_q, lo_d, hi_q, hi_d;
  token_t           tok_q, tok_d;
  logic             split;
  logic             is_target, is_left;
  logic [WIN_W:0]   sum;
  logic [WIN_W-1:0] avg;
  logic [WIN_W-1:0] sample_ext;

  // loads past the table touch no entry, not even the last one's low bound
  assign split      = (tok_i.idx > IDX_W'(1)) && (tok_i.idx < IDX_W'(CAL_ENTRIES));
  assign is_target  = tok_i.idx == cell_idx_i;
  assign is_left    = {1'b0, tok_i.idx} == ({1'b0, cell_idx_i} + (IDX_W+1)'(1));
  assign sum        = {1'b0, lo_q} + {1'b0, tok_i.hi};
  assign avg        = sum[WIN_W:1];
  assign sample_ext = WIN_W'(tok_i.sample);

  // Window update and match for the item passing through
  always_comb begin
    tok_d = tok_i;
    lo_d  = lo_q;
    hi_d  = hi_q;
    if (tok_i.valid) begin
      if (tok_i.op == OP_LOAD) begin
        if (is_target) begin
          lo_d = tok_i.lo;
          hi_d = split ? tok_i.split_hi : tok_i.hi;
        end
        // left neighbor of the loaded entry splits the overlap
        if (split && is_left) begin
          lo_d           = avg + WIN_W'(1);
          tok_d.split_hi = avg;
        end
      end else begin
        if (!tok_i.found && (cell_idx_i < IDX_W'(MATCH_ENTRIES)) &&
            (sample_ext >= lo_q) && (sample_ext <= hi_q)) begin
          tok_d.found   = 1'b1;
          tok_d.hit_idx = cell_idx_i;
        end
      end
    end
  end

  // Window bounds: payload only
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  // Token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### hw/rtl/rlbd_debounce.sv
// Debounce tracker at the end of the chain: button state, counters, result.
// Depends on rlbd_pkg.
module rlbd_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rlbd_pkg::token_t              tok_i,
  input  logic [rlbd_pkg::CNT_W-1:0]    miss_limit_i,
  input  logic [rlbd_pkg::CNT_W-1:0]    repeat_target_i,
  output logic                          result_valid_o,
  output logic signed [rlbd_pkg::CODE_W-1:0] result_code_o
);
  import rlbd_pkg::*;

  logic               has_q, has_d;
  logic [IDX_W-1:0]   btn_q, btn_d;
  logic [CNT_W-1:0]   rep_q, rep_d, miss_q, miss_d;
  logic [CNT_W-1:0]   rep_inc, miss_inc;
  logic               valid_q, valid_d;
  logic signed [CODE_W-1:0] code_q, code_d;

  assign rep_inc  = (rep_q == CNT_MAX) ? rep_q : rep_q + CNT_W'(1);
  assign miss_inc = (miss_q == CNT_MAX) ? miss_q : miss_q + CNT_W'(1);

  // Next button state and result code
  always_comb begin
    has_d   = has_q;
    btn_d   = btn_q;
    rep_d   = rep_q;
    miss_d  = miss_q;
    valid_d = tok_i.valid && (tok_i.op == OP_SAMPLE);
    if (valid_d) begin
      if (tok_i.found) begin
        if (has_q && (btn_q == tok_i.hit_idx)) begin
          rep_d = rep_inc;
        end else begin
          miss_d = miss_inc;
          if ((miss_inc >= miss_limit_i) || !has_q) begin
            has_d  = 1'b1;
            btn_d  = tok_i.hit_idx;
            rep_d  = CNT_W'(1);
            miss_d = '0;
          end
        end
      end else begin
        miss_d = miss_inc;
        if (miss_inc >= miss_limit_i) begin
          has_d = 1'b0;
        end
      end
    end
    if (has_d && (btn_d != '0)) begin
      code_d = (rep_d == repeat_target_i) ? CODE_W'(btn_d) : CODE_NONE;
    end else if (has_d) begin
      code_d = CODE_ZERO;
    end else begin
      code_d = CODE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q   <= 1'b0;
      btn_q   <= '0;
      rep_q   <= '0;
      miss_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      has_q   <= has_d;
      btn_q   <= btn_d;
      rep_q   <= rep_d;
      miss_q  <= miss_d;
      valid_q <= valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign result_valid_o = valid_q;
  assign result_code_o  = code_q;

endmodule

### tb/sv/rlbd_checker.sv
`timescale 1ns / 100ps
// Checker for the resistor-ladder button decoder: mirrors the calibration
// windows and the debounce state, predicts each sample code and compares it.
// Depends on rlbd_pkg.
module rlbd_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic                               op_i,
  input  logic [rlbd_pkg::IDX_W-1:0]         idx_i,
  input  logic [rlbd_pkg::SAMPLE_BITS-1:0]   level_i,
  input  logic                               cfg_we_i,
  input  logic [rlbd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rlbd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               res_valid_i,
  input  logic signed [rlbd_pkg::CODE_W-1:0] res_code_i,
  output int                                 mismatches_o,
  output int                                 codes_waiting_o
);
  import rlbd_pkg::*;

  localparam int NO_BUTTON = -1;

  // Register values after reset
  localparam logic [HALF_W-1:0] RST_HALF_WIDTH    = 10'd5;
  localparam logic [CNT_W-1:0]  RST_MISS_LIMIT    = 8'd3;
  localparam logic [CNT_W-1:0]  RST_REPEAT_TARGET = 8'd8;

  // Mirrored block state
  logic [WIN_W-1:0]  win_lo [CAL_ENTRIES];
  logic [WIN_W-1:0]  win_hi [CAL_ENTRIES];
  int                cur_btn;
  logic [CNT_W-1:0]  repeat_cnt;
  logic [CNT_W-1:0]  miss_cnt;

  // Mirrored registers
  logic [HALF_W-1:0] half_width;
  logic [CNT_W-1:0]  miss_limit;
  logic [CNT_W-1:0]  repeat_target;

  logic signed [CODE_W-1:0] expected_codes [$];
  logic signed [CODE_W-1:0] code_now;
  logic signed [CODE_W-1:0] want_code;
  int                       mismatches;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Load one calibration level; entries past the table are dropped
  task automatic apply_load(input logic [IDX_W-1:0] idx, input logic [SAMPLE_BITS-1:0] lvl);
    logic [WIN_W:0] mid_sum;
    if (idx >= CAL_ENTRIES) return;
    win_lo[idx] = (lvl > half_width) ? {1'b0, lvl - half_width} : '0;
    win_hi[idx] = {1'b0, lvl} + {1'b0, half_width};
    // split the overlap with the left neighbor at its midpoint
    if (idx > 1) begin
      mid_sum         = {1'b0, win_lo[idx - 1'b1]} + {1'b0, win_hi[idx]};
      win_lo[idx - 1'b1] = mid_sum[WIN_W:1] + 1'b1;
      win_hi[idx]        = mid_sum[WIN_W:1];
    end
  endtask

  // Match a sample, step the debouncer and form the result code
  task automatic predict_code(input logic [SAMPLE_BITS-1:0] s,
                              output logic signed [CODE_W-1:0] code);
    int hit;
    hit = NO_BUTTON;
    for (int i = 0; i < MATCH_ENTRIES; i++) begin
      if (hit < 0 && {1'b0, s} >= win_lo[i] && {1'b0, s} <= win_hi[i]) hit = i;
    end
    if (hit >= 0) begin
      if (cur_btn == hit) begin
        repeat_cnt = bump(repeat_cnt);
      end else begin
        miss_cnt = bump(miss_cnt);
        if (miss_cnt >= miss_limit || cur_btn < 0) begin
          repeat_cnt = CNT_W'(1);
          miss_cnt   = '0;
          cur_btn    = hit;
        end
      end
    end else begin
      miss_cnt = bump(miss_cnt);
      if (miss_cnt >= miss_limit) cur_btn = NO_BUTTON;
    end
    if (cur_btn > 0) begin
      code = (repeat_cnt == repeat_target) ? cur_btn[CODE_W-1:0] : CODE_NONE;
    end else if (cur_btn == 0) begin
      code = CODE_ZERO;
    end else begin
      code = CODE_NONE;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAL_ENTRIES; i++) begin
        win_lo[i] = '0;
        win_hi[i] = '0;
      end
      cur_btn       = NO_BUTTON;
      repeat_cnt    = '0;
      miss_cnt      = '0;
      half_width    = RST_HALF_WIDTH;
      miss_limit    = RST_MISS_LIMIT;
      repeat_target = RST_REPEAT_TARGET;
      expected_codes.delete();
      mismatches      = 0;
      mismatches_o    <= 0;
      codes_waiting_o <= 0;
    end else begin
      // each result retires the oldest expected code
      if (res_valid_i) begin
        if (expected_codes.size() == 0) begin
          $error("result_code: no item waiting, actual %0d", res_code_i);
          mismatches++;
        end else begin
          want_code = expected_codes.pop_front();
          if (res_code_i !== want_code) begin
            $error("result_code: expected %0d, actual %0d", want_code, res_code_i);
            mismatches++;
          end
        end
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HALF_WIDTH:    half_width    = cfg_wdata_i[HALF_W-1:0];
          CFG_MISS_LIMIT:    miss_limit    = cfg_wdata_i[CNT_W-1:0];
          CFG_REPEAT_TARGET: repeat_target = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      // accepted item
      if (start_i && !busy_i) begin
        if (op_i == OP_SAMPLE) begin
          predict_code(level_i, code_now);
          expected_codes.push_back(code_now);
        end else begin
          apply_load(idx_i, level_i);
        end
      end
      mismatches_o    <= mismatches;
      codes_waiting_o <= expected_codes.size();
    end
  end

endmodule

### tb/sv/tb_resistor_ladder_button_decoder.sv
`timescale 1ns / 100ps
// Testbench top for the resistor-ladder button decoder: clock, reset, item
// and register stimulus, and the verdict. Depends on rlbd_pkg, rlbd_checker
// and the decoder RTL.
module tb_resistor_ladder_button_decoder;
  import rlbd_pkg::*;

  localparam int LATENCY     = 18;
  localparam int TAIL        = LATENCY + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LEVEL_MAX   = (1 << SAMPLE_BITS) - 1;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     operation_i;
  logic [IDX_W-1:0]         entry_index_i;
  logic [SAMPLE_BITS-1:0]   level_i;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_wdata_i;
  logic                     result_valid_o;
  logic signed [CODE_W-1:0] result_code_o;

  int  mismatches;
  int  codes_waiting;
  int  cycle_count = 0;
  int  n_loads     = 0;
  int  n_samples   = 0;
  int  n_settings  = 0;
  int  ladder_base;
  int  ladder_step;
  int  step;
  bit  steady;

  resistor_ladder_button_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .level_i        (level_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_code_o  (result_code_o)
  );

  rlbd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .op_i            (operation_i),
    .idx_i           (entry_index_i),
    .level_i         (level_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .res_valid_i     (result_valid_o),
    .res_code_i      (result_code_o),
    .mismatches_o    (mismatches),
    .codes_waiting_o (codes_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Ladder rung level, clipped to the sample range
  function automatic int rung_level(input int b);
    int v;
    v = ladder_base + b * ladder_step;
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

  // A sample at or a little below rung b
  function automatic int near_level(input int b, input int jit);
    int v;
    v = rung_level(b) - $urandom_range(0, jit);
    return (v < 0) ? 0 : v;
  endfunction

  // Send one item; the idle gap counts ready cycles with start low
  task automatic send_item(input op_e op, input int idx, input int lvl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      repeat (gap - 1) @(posedge clk_i);
    end
    start         <= 1'b1;
    operation_i   <= op;
    entry_index_i <= idx[IDX_W-1:0];
    level_i       <= lvl[SAMPLE_BITS-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OP_LOAD) n_loads++;
    else n_samples++;
  endtask

  // Drain: every code in, then enough cycles for a trailing load item
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (codes_waiting != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  task automatic program_cfg(input int hw, input int ml, input int rt);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HALF_WIDTH;
    cfg_wdata_i <= hw[CFG_W-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MISS_LIMIT;
    cfg_wdata_i <= ml[CFG_W-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= CFG_REPEAT_TARGET;
    cfg_wdata_i <= rt[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  // Load every entry in index order
  task automatic calibrate();
    for (int i = 0; i < CAL_ENTRIES; i++) send_item(OP_LOAD, i, rung_level(i));
  endtask

  // One register setting: fresh ladder, then press bursts mixed with noise
  task automatic run_phase(input int hw, input int ml, input int rt,
                           input int rung_step, input int budget);
    int first;
    int b;
    int n;
    int jit;
    int pick;
    int burst_max;
    bit paused;
    settle();
    program_cfg(hw, ml, rt);
    ladder_step = rung_step;
    ladder_base = $urandom_range(0, LEVEL_MAX - 16 * rung_step);
    calibrate();
    first     = n_loads + n_samples;
    jit       = (hw < rung_step) ? hw / 2 : rung_step / 2;
    burst_max = (rt > 0 && rt < 20) ? rt + 3 : 20;
    paused    = 1'b0;
    while (n_loads + n_samples - first < budget) begin
      pick   = $urandom_range(0, 9);
      steady = ($urandom_range(0, 3) == 0);
      if (pick < 7) begin
        // press: reload the rung so its window opens, then hold it
        b = $urandom_range(0, MATCH_ENTRIES - 1);
        if (b > 0) send_item(OP_LOAD, b, rung_level(b));
        n = $urandom_range(1, burst_max);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) begin
            send_item(OP_SAMPLE, $urandom_range(0, 31), $urandom_range(0, LEVEL_MAX));
          end else begin
            send_item(OP_SAMPLE, $urandom_range(0, 31), near_level(b, jit));
          end
        end
      end else if (pick < 9) begin
        send_item(OP_SAMPLE, $urandom_range(0, 31), $urandom_range(0, LEVEL_MAX));
      end else begin
        // out-of-order or out-of-range load
        send_item(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, LEVEL_MAX));
      end
      // hold off once mid-phase until every code is back
      if (!paused && 2 * (n_loads + n_samples - first) > budget) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  // Both counters driven into saturation at the widest limits
  task automatic saturate_counters();
    int b;
    settle();
    program_cfg(30, 255, 255);
    ladder_step = 50;
    ladder_base = $urandom_range(0, LEVEL_MAX - 16 * ladder_step);
    calibrate();
    // only rungs 0 and 1 hold open windows here, so high samples all miss
    repeat (258) begin
      steady = ($urandom_range(0, 3) == 0);
      send_item(OP_SAMPLE, 0, $urandom_range(ladder_base + 100, LEVEL_MAX));
    end
    b = $urandom_range(2, MATCH_ENTRIES - 1);
    send_item(OP_LOAD, b, rung_level(b));
    repeat (258) begin
      steady = ($urandom_range(0, 3) == 0);
      send_item(OP_SAMPLE, 0, near_level(b, 15));
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    operation_i   <= OP_LOAD;
    entry_index_i <= '0;
    level_i       <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_HALF_WIDTH;
    cfg_wdata_i   <= '0;
    steady        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full ladder from 0 to 1023 under reset settings
    ladder_base = 0;
    ladder_step = 64;
    calibrate();
    send_item(OP_LOAD, 31, LEVEL_MAX);  // past the table, dropped
    send_item(OP_LOAD, CAL_ENTRIES, 0);
    send_item(OP_SAMPLE, 0, 0);         // button 0
    send_item(OP_SAMPLE, 31, 3);        // repeat
    send_item(OP_SAMPLE, 0, LEVEL_MAX); // misses until cleared
    send_item(OP_SAMPLE, 0, 512);
    send_item(OP_SAMPLE, 0, 700);
    send_item(OP_SAMPLE, 0, 0);         // back to button 0

    // Random phases
    run_phase(0, 1, 1, $urandom_range(40, 60), 40);
    run_phase(LEVEL_MAX, 255, 255, 50, 25);
    step = $urandom_range(40, 60);
    run_phase((3 * step) / 5, 0, 0, step, 35);
    repeat (2) begin
      step = $urandom_range(40, 60);
      run_phase((3 * step) / 5, $urandom_range(1, 4), $urandom_range(1, 12), step, 75);
    end
    saturate_counters();
    settle();

    $display("Sent %0d calibration loads and %0d ADC samples under %0d register settings,",
             n_loads, n_samples, n_settings);
    $display("with zero and maximum debounce limits, saturated counters and stray indexes.");
    if (mismatches == 0 && codes_waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rlbd_pkg.sv
hw/rtl/rlbd_cell.sv
hw/rtl/rlbd_debounce.sv
hw/rtl/resistor_ladder_button_decoder.sv
tb/sv/rlbd_checker.sv
tb/sv/tb_resistor_ladder_button_decoder.sv
